// ===== rtl/core/dde_pkg.sv =====
package dde_pkg;

	localparam int DIGITS_DEF = 10;
	localparam int QDEPTH     = 2;

	// floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for every 32-bit v
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		logic [31:0] number_in;
		logic [7:0]  pad_count;
		logic [1:0]  glyph_size;
	} item_t;

	typedef struct packed {
		logic [3:0] digit_value;
		logic       is_blank;
		logic [1:0] size_tag;
		logic       last_one;
	} result_t;

	typedef struct packed {
		logic [7:0] pad;
		logic [1:0] tag;
	} meta_t;

endpackage

// ===== rtl/core/dde_front.sv =====
module dde_front #(
	parameter int DIGITS = dde_pkg::DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  dde_pkg::item_t        item,
	input  logic                  full,
	output logic                  push,
	output logic [DIGITS*4-1:0]   push_digs,
	output logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] push_top,
	output dde_pkg::meta_t        push_meta
);

	localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic                active_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       top_q;
	logic [31:0]         val_q;
	logic [DIGITS*4-1:0] digs_q;
	dde_pkg::meta_t      meta_q;

	logic [63:0]         prod;
	logic [31:0]         quo;
	logic [31:0]         quo10;
	logic [31:0]         diff;
	logic [3:0]          rem;
	logic [CW-1:0]       top_nx;
	logic [DIGITS*4-1:0] digs_nx;
	logic                last;
	logic                step;
	logic                accept;

	always_comb begin
		prod  = 64'(val_q) * 64'(dde_pkg::RECIP10);
		quo   = 32'(prod >> dde_pkg::RECIP_SHIFT);
		quo10 = (quo << 3) + (quo << 1);
		diff  = val_q - quo10;
		rem   = diff[3:0];
		top_nx = (rem != 4'd0) ? cnt_q : top_q;
		// shift the new digit in at the top: units digit ends up at the bottom
		for (int i = 0; i < DIGITS - 1; i++) begin
			digs_nx[i*4 +: 4] = digs_q[(i+1)*4 +: 4];
		end
		digs_nx[(DIGITS-1)*4 +: 4] = rem;
	end

	assign last   = (cnt_q == CW'(DIGITS - 1));
	assign step   = active_q && !(last && full);
	assign busy   = active_q && !(last && !full);
	assign accept = start && !busy;
	assign push   = active_q && last && !full;

	assign push_digs = digs_nx;
	assign push_top  = top_nx;
	assign push_meta = meta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			top_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
			top_q    <= '0;
		end else if (step) begin
			cnt_q <= CW'(cnt_q + 1'b1);
			top_q <= top_nx;
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q      <= item.number_in;
			meta_q.pad <= item.pad_count;
			meta_q.tag <= item.glyph_size;
		end else if (step) begin
			val_q  <= quo;
			digs_q <= digs_nx;
		end
	end

endmodule

// ===== rtl/core/dde_queue.sv =====
module dde_queue #(
	parameter int DIGITS = dde_pkg::DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DIGITS*4-1:0]   push_digs,
	input  logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] push_top,
	input  dde_pkg::meta_t        push_meta,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output logic [DIGITS*4-1:0]   head_digs,
	output logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] head_top,
	output dde_pkg::meta_t        head_meta
);

	localparam int CW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int QPW = (dde_pkg::QDEPTH > 1) ? $clog2(dde_pkg::QDEPTH) : 1;

	logic [DIGITS*4-1:0] digs_mem [dde_pkg::QDEPTH];
	logic [CW-1:0]       top_mem  [dde_pkg::QDEPTH];
	dde_pkg::meta_t      meta_mem [dde_pkg::QDEPTH];

	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   count_q;

	assign full  = (count_q == (QPW+1)'(dde_pkg::QDEPTH));
	assign empty = (count_q == '0);

	assign head_digs = digs_mem[rd_ptr_q];
	assign head_top  = top_mem[rd_ptr_q];
	assign head_meta = meta_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(dde_pkg::QDEPTH - 1)) ? '0
				            : QPW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(dde_pkg::QDEPTH - 1)) ? '0
				            : QPW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (QPW+1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (QPW+1)'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			digs_mem[wr_ptr_q] <= push_digs;
			top_mem[wr_ptr_q]  <= push_top;
			meta_mem[wr_ptr_q] <= push_meta;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

// ===== rtl/core/dde_back.sv =====
module dde_back #(
	parameter int DIGITS = dde_pkg::DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  logic [DIGITS*4-1:0]   head_digs,
	input  logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] head_top,
	input  dde_pkg::meta_t        head_meta,
	output logic                  pop,
	output logic                  strobe,
	output dde_pkg::result_t      result
);

	localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic                active_q;
	logic [CW-1:0]       blank_q;
	logic [CW-1:0]       pos_q;
	logic                strobe_q;
	dde_pkg::result_t    result_q;
	logic [DIGITS*4-1:0] dig_q;
	logic [1:0]          tag_q;

	logic [CW-1:0]       lead;
	logic [CW-1:0]       blanks;
	logic                last_emit;
	logic                load;
	dde_pkg::result_t    out_nx;

	always_comb begin
		// leading zero positions above the first significant digit
		lead   = CW'(DIGITS - 1) - head_top;
		blanks = (head_meta.pad < 8'(lead)) ? CW'(head_meta.pad) : lead;

		out_nx.size_tag = tag_q;
		if (blank_q != '0) begin
			out_nx.digit_value = 4'd0;
			out_nx.is_blank    = 1'b1;
			out_nx.last_one    = 1'b0;
		end else begin
			out_nx.digit_value = dig_q[{pos_q, 2'b00} +: 4];
			out_nx.is_blank    = 1'b0;
			out_nx.last_one    = (pos_q == '0);
		end
	end

	assign last_emit = active_q && (blank_q == '0) && (pos_q == '0);
	assign load      = !empty && (!active_q || last_emit);
	assign pop       = load;
	assign strobe    = strobe_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			blank_q  <= '0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				blank_q  <= blanks;
				pos_q    <= head_top;
			end else if (last_emit) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (blank_q != '0) begin
					blank_q <= CW'(blank_q - 1'b1);
				end else begin
					pos_q <= CW'(pos_q - 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q <= out_nx;
		end
		if (load) begin
			dig_q <= head_digs;
			tag_q <= head_meta.tag;
		end
	end

	a_blank_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.is_blank |-> !result_q.last_one && result_q.digit_value == 4'd0)
		else $error("blank word ends a run or carries a digit");

	a_blanks_first: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && blank_q != '0 |=> strobe_q && result_q.is_blank)
		else $error("pending blank not emitted");

endmodule

// ===== rtl/core/decimal_digit_emitter_blanking_top.sv =====
// Throughput: the divide-by-ten unit yields one digit per cycle while the
// queue is not full, and a new item is taken as the last digit of the one
// before is pushed; the back end emits one word per cycle, up to DIGITS
// words per item, and a two-entry queue sits between the two.
// Reset (arst_n low) clears control state only; no clearing pass is needed.
// The receiver cannot stall: each word is shown for exactly one cycle.
module decimal_digit_emitter_blanking_top #(
	parameter int DIGITS = dde_pkg::DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  dde_pkg::item_t   item,
	output logic             strobe,
	output dde_pkg::result_t result
);

	localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic                push;
	logic                full;
	logic [DIGITS*4-1:0] push_digs;
	logic [CW-1:0]       push_top;
	dde_pkg::meta_t      push_meta;
	logic                pop;
	logic                empty;
	logic [DIGITS*4-1:0] head_digs;
	logic [CW-1:0]       head_top;
	dde_pkg::meta_t      head_meta;

	dde_front #(.DIGITS(DIGITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.full      (full),
		.push      (push),
		.push_digs (push_digs),
		.push_top  (push_top),
		.push_meta (push_meta)
	);

	dde_queue #(.DIGITS(DIGITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_digs (push_digs),
		.push_top  (push_top),
		.push_meta (push_meta),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head_digs (head_digs),
		.head_top  (head_top),
		.head_meta (head_meta)
	);

	dde_back #(.DIGITS(DIGITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_digs (head_digs),
		.head_top  (head_top),
		.head_meta (head_meta),
		.pop       (pop),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

// ===== tb/testbench.sv =====
module testbench;

	localparam int NDIG       = dde_pkg::DIGITS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM   = 100;

	// Expected digit words per accepted number, checked in arrival order
	class digit_ledger;
		dde_pkg::result_t due_words[$];
		int      errors;
		int      numbers_logged;
		int      words_checked;
		int      blanks_seen;

		function void log_number(dde_pkg::item_t it);
			logic [3:0]       dig [NDIG];
			longint unsigned  v;
			int               pad;
			bit               lead;
			dde_pkg::result_t w;
			v    = it.number_in;
			pad  = it.pad_count;
			lead = 1'b1;
			for (int i = 0; i < NDIG; i++) begin
				dig[i] = 4'(v % 10);
				v      = v / 10;
			end
			for (int i = NDIG - 1; i >= 0; i--) begin
				w.size_tag = it.glyph_size;
				// units digit is always sent and always closes the run
				w.last_one = (i == 0);
				if (lead && dig[i] == 4'd0 && i != 0) begin
					if (pad != 0) begin
						w.digit_value = 4'd0;
						w.is_blank    = 1'b1;
						due_words.push_back(w);
						pad--;
					end
				end else begin
					lead          = 1'b0;
					w.digit_value = dig[i];
					w.is_blank    = 1'b0;
					due_words.push_back(w);
				end
			end
			numbers_logged++;
		endfunction

		function void match_word(dde_pkg::result_t got);
			dde_pkg::result_t want;
			if (due_words.size() == 0) begin
				$error("digit word %h arrived with none expected", got);
				errors++;
				return;
			end
			want = due_words.pop_front();
			words_checked++;
			if (want.is_blank)
				blanks_seen++;
			if (got.digit_value !== want.digit_value) begin
				$error("digit_value: expected %0d, got %0d", want.digit_value, got.digit_value);
				errors++;
			end
			if (got.is_blank !== want.is_blank) begin
				$error("is_blank: expected %0b, got %0b", want.is_blank, got.is_blank);
				errors++;
			end
			if (got.size_tag !== want.size_tag) begin
				$error("size_tag: expected %0d, got %0d", want.size_tag, got.size_tag);
				errors++;
			end
			if (got.last_one !== want.last_one) begin
				$error("last_one: expected %0b, got %0b", want.last_one, got.last_one);
				errors++;
			end
		endfunction

		function int pending();
			return due_words.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	dde_pkg::item_t   item;
	logic             strobe;
	dde_pkg::result_t result;

	digit_ledger ledger = new();
	int          idle_cycles;

	decimal_digit_emitter_blanking_top #(
		.DIGITS(NDIG)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Monitor and watchdog: log accepted numbers, check each strobed word
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			ledger.log_number(item);
		if (arst_n && strobe)
			ledger.match_word(result);
		if ((arst_n && start && !busy) || (arst_n && strobe)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic dde_pkg::item_t mk(logic [31:0] num, logic [7:0] pad, logic [1:0] font);
		dde_pkg::item_t it;
		it.number_in  = num;
		it.pad_count  = pad;
		it.glyph_size = font;
		return it;
	endfunction

	function automatic longint unsigned ten_pow(int k);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < k; i++)
			p = p * 10;
		return p;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic dde_pkg::item_t random_number();
		logic [31:0] num;
		int          k;
		int          mode;
		num  = $urandom;
		mode = $urandom_range(0, 3);
		k    = $urandom_range(1, 9);
		case (mode)
			0: ;
			1: num = 32'(num % ten_pow(k));
			2: num = 32'(ten_pow(k) * $urandom_range(1, 4));
			default: num = $urandom_range(0, 99);
		endcase
		return mk(num,
			($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12)),
			2'($urandom_range(0, 3)));
	endfunction

	// Hold the word on the bus until taken, then idle for gap cycles
	task automatic send(dde_pkg::item_t it, int gap);
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.pending() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, font tags, padding edges
		send(mk(32'd0, 8'd0, 2'd0), 0);
		send(mk(32'd0, 8'd255, 2'd1), 0);
		send(mk(32'd0, 8'd4, 2'd2), 0);
		send(mk(32'hFFFF_FFFF, 8'd255, 2'd3), 0);
		send(mk(32'hFFFF_FFFF, 8'd0, 2'd0), 1);
		send(mk(32'd1, 8'd9, 2'd1), 0);
		send(mk(32'd1, 8'd10, 2'd2), 0);
		send(mk(32'd9, 8'd3, 2'd3), 0);
		send(mk(32'd10, 8'd255, 2'd0), 2);
		send(mk(32'd100, 8'd1, 2'd1), 0);
		send(mk(32'd10000, 8'd2, 2'd2), 0);
		send(mk(32'd999_999_999, 8'd255, 2'd0), 0);
		send(mk(32'd1_000_000_000, 8'd5, 2'd1), 0);
		send(mk(32'd4_000_000_000, 8'd0, 2'd2), 0);
		send(mk(32'd1_000_000_001, 8'd170, 2'd3), 0);
		send(mk(32'd12345, 8'd85, 2'd0), 5);
		send(mk(32'hAAAA_AAAA, 8'd8, 2'd1), 0);
		send(mk(32'h5555_5555, 8'd128, 2'd2), 0);
		send(mk(32'd7, 8'd0, 2'd3), 0);

		// hold off until every word is back
		drain();

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2)
				drain();
			// a stretch with the sender never idling
			send(random_number(), (n >= 30 && n < 50) ? 0 : pick_gap());
		end

		drain();
		repeat (NDIG + 6) @(posedge clk);

		$display("Checked %0d numbers: %0d digit words, %0d of them blanks.",
			ledger.numbers_logged, ledger.words_checked, ledger.blanks_seen);
		$display("Values from zero to all ones, padding 0 to 255, all four size tags.");
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/dde_pkg.sv
rtl/core/dde_front.sv
rtl/core/dde_queue.sv
rtl/core/dde_back.sv
rtl/core/decimal_digit_emitter_blanking_top.sv
tb/testbench.sv
